>>> hdl/xie_pkg.sv
// ----------------------------------------------------------------------------
// xie_pkg
// Shared types and constants of the x86 instruction byte encoder.
// ----------------------------------------------------------------------------
package xie_pkg;

  localparam int unsigned MaxBytes = 7;

  // instruction kinds
  localparam logic [3:0] CMD_PUSH    = 4'd0;
  localparam logic [3:0] CMD_POP     = 4'd1;
  localparam logic [3:0] CMD_MOV_RR  = 4'd2;
  localparam logic [3:0] CMD_LOAD    = 4'd3;
  localparam logic [3:0] CMD_STORE   = 4'd4;
  localparam logic [3:0] CMD_MOV_IMM = 4'd5;
  localparam logic [3:0] CMD_CALL_R  = 4'd6;
  localparam logic [3:0] CMD_CALL_REL = 4'd7;
  localparam logic [3:0] CMD_ADD_RR  = 4'd8;
  localparam logic [3:0] CMD_ADD_IMM = 4'd9;
  localparam logic [3:0] CMD_RET     = 4'd10;
  localparam logic [3:0] CMD_CMP     = 4'd11;
  localparam logic [3:0] CMD_TEST    = 4'd12;
  localparam logic [3:0] CMD_INT3    = 4'd13;

  // opcodes
  localparam logic [7:0] OP_PUSH     = 8'h50;
  localparam logic [7:0] OP_POP      = 8'h58;
  localparam logic [7:0] OP_MOV_LD   = 8'h8B;
  localparam logic [7:0] OP_MOV_ST   = 8'h89;
  localparam logic [7:0] OP_MOV_IMM  = 8'hB8;
  localparam logic [7:0] OP_GRP5     = 8'hFF;
  localparam logic [7:0] OP_CALL_REL = 8'hE8;
  localparam logic [7:0] OP_ADD_RR   = 8'h03;
  localparam logic [7:0] OP_ADD_IB   = 8'h83;
  localparam logic [7:0] OP_ADD_ID   = 8'h81;
  localparam logic [7:0] OP_RET      = 8'hC3;
  localparam logic [7:0] OP_RET_IW   = 8'hC2;
  localparam logic [7:0] OP_CMP_RR   = 8'h3B;
  localparam logic [7:0] OP_TEST_RR  = 8'h85;
  localparam logic [7:0] OP_INT3     = 8'hCC;
  localparam logic [7:0] SIB_ESP     = 8'h24;

  localparam logic [2:0] REG_ESP = 3'd4;
  localparam logic [2:0] REG_EBP = 3'd5;

  localparam logic [1:0] MOD_NODISP = 2'd0;
  localparam logic [1:0] MOD_DISP8  = 2'd1;
  localparam logic [1:0] MOD_DISP32 = 2'd2;
  localparam logic [1:0] MOD_REG    = 2'd3;

  // one encoded instruction waiting to be serialized
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [2:0]               len;
    logic [31:0]              start;
    logic [31:0]              patch;
  } xie_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } xie_qstat_t;

endpackage

>>> hdl/xie_if.sv
// ----------------------------------------------------------------------------
// xie_if
// Request and code byte channels of the x86 instruction byte encoder.
// ----------------------------------------------------------------------------
interface xie_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  cmd;
  logic [2:0]  reg_a;
  logic [2:0]  reg_b;
  logic [31:0] imm;

  modport source (output valid, output cmd, output reg_a, output reg_b, output imm,
                  input ready);
  modport sink (input valid, input cmd, input reg_a, input reg_b, input imm,
                output ready);
endinterface

interface xie_code_if;
  logic        valid;
  logic        ready;
  logic [7:0]  code_byte;
  logic        last_byte;
  logic [31:0] start_offset;
  logic [31:0] patch_offset;

  modport source (output valid, output code_byte, output last_byte,
                  output start_offset, output patch_offset, input ready);
  modport sink (input valid, input code_byte, input last_byte,
                input start_offset, input patch_offset, output ready);
endinterface

>>> hdl/x86_instruction_byte_encoder.sv
// ----------------------------------------------------------------------------
// x86_instruction_byte_encoder
// Encodes 32-bit x86 instruction requests into a stream of code bytes.
// ----------------------------------------------------------------------------
// the first byte of an instruction passes the instruction queue and then the
//   output register before it appears on the code channel
// one code byte per cycle while code_o is ready and the queue is not empty;
//   an instruction of 1 to 7 bytes leaves through the single-byte output register
// a request transfers every cycle while the instruction queue has room
// reset clears the code offset to zero and empties queue and output register
module x86_instruction_byte_encoder import xie_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  xie_req_if.sink    req_i,
  xie_code_if.source code_o
);

  xie_entry_t entry, head;
  xie_qstat_t qstat;
  logic       push, pop;

  xie_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .qstat_i (qstat),
    .push_o  (push),
    .entry_o (entry)
  );

  xie_queue #(.Depth(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .qstat_o (qstat)
  );

  xie_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .qstat_i (qstat),
    .pop_o   (pop),
    .code_o  (code_o)
  );

  // a nonzero patch offset always points just past the call opcode
  a_patch_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    code_o.valid && code_o.patch_offset != 32'd0
      |-> code_o.patch_offset == code_o.start_offset + 32'd1)
    else $error("patch offset does not follow start offset");

  // bytes of one instruction follow each other without gaps
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    code_o.valid && code_o.ready && !code_o.last_byte
      |=> code_o.valid && code_o.start_offset == $past(code_o.start_offset))
    else $error("gap or offset change inside an instruction");

  // the queue never pops while empty nor signals full and empty together
  a_queue_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(qstat.full && qstat.empty) && !(pop && qstat.empty))
    else $error("instruction queue state inconsistent");

  // a pushed instruction is never dropped by a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !qstat.full)
    else $error("push into full instruction queue");

endmodule

>>> hdl/xie_front.sv
// ----------------------------------------------------------------------------
// xie_front
// Accepts requests, encodes them into byte groups and tracks the code offset.
// ----------------------------------------------------------------------------
module xie_front import xie_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  xie_req_if.sink    req_i,
  input  xie_qstat_t qstat_i,
  output logic       push_o,
  output xie_entry_t entry_o
);

  logic [31:0]              offset_q, offset_d;
  logic [MaxBytes-1:0][7:0] bytes;
  logic [2:0]               len;
  logic [2:0]               mem_r, mem_base, dpos;
  logic [1:0]               mode;
  logic                     imm_small;
  logic                     accept;

  assign imm_small = (req_i.imm[31:7] == 25'd0);

  // memory operand selection for load and store
  always_comb begin
    if (req_i.cmd == CMD_LOAD) begin
      mem_r    = req_i.reg_a;
      mem_base = req_i.reg_b;
    end else begin
      mem_r    = req_i.reg_b;
      mem_base = req_i.reg_a;
    end
    if (req_i.imm == 32'd0 && mem_base != REG_EBP) begin
      mode = MOD_NODISP;
    end else if (imm_small) begin
      mode = MOD_DISP8;
    end else begin
      mode = MOD_DISP32;
    end
    dpos = (mem_base == REG_ESP) ? 3'd3 : 3'd2;
  end

  always_comb begin
    bytes = '0;
    len   = 3'd0;
    unique case (req_i.cmd)
      CMD_PUSH: begin
        bytes[0] = OP_PUSH | {5'd0, req_i.reg_a};
        len      = 3'd1;
      end
      CMD_POP: begin
        bytes[0] = OP_POP | {5'd0, req_i.reg_a};
        len      = 3'd1;
      end
      CMD_MOV_RR, CMD_ADD_RR, CMD_CMP: begin
        if (req_i.cmd == CMD_MOV_RR) begin
          bytes[0] = OP_MOV_LD;
        end else if (req_i.cmd == CMD_ADD_RR) begin
          bytes[0] = OP_ADD_RR;
        end else begin
          bytes[0] = OP_CMP_RR;
        end
        bytes[1] = {MOD_REG, req_i.reg_a, req_i.reg_b};
        len      = 3'd2;
      end
      CMD_LOAD, CMD_STORE: begin
        bytes[0] = (req_i.cmd == CMD_LOAD) ? OP_MOV_LD : OP_MOV_ST;
        bytes[1] = {mode, mem_r, mem_base};
        if (mem_base == REG_ESP) begin
          bytes[2] = SIB_ESP;
        end
        if (mode == MOD_DISP8) begin
          bytes[dpos] = req_i.imm[7:0];
          len         = dpos + 3'd1;
        end else if (mode == MOD_DISP32) begin
          bytes[dpos]        = req_i.imm[7:0];
          bytes[dpos + 3'd1] = req_i.imm[15:8];
          bytes[dpos + 3'd2] = req_i.imm[23:16];
          bytes[dpos + 3'd3] = req_i.imm[31:24];
          len                = dpos + 3'd4;
        end else begin
          len = dpos;
        end
      end
      CMD_MOV_IMM, CMD_CALL_REL: begin
        bytes[0] = (req_i.cmd == CMD_MOV_IMM) ? (OP_MOV_IMM | {5'd0, req_i.reg_a})
                                              : OP_CALL_REL;
        bytes[1] = req_i.imm[7:0];
        bytes[2] = req_i.imm[15:8];
        bytes[3] = req_i.imm[23:16];
        bytes[4] = req_i.imm[31:24];
        len      = 3'd5;
      end
      CMD_CALL_R: begin
        bytes[0] = OP_GRP5;
        bytes[1] = {MOD_REG, 3'd2, req_i.reg_a};
        len      = 3'd2;
      end
      CMD_ADD_IMM: begin
        bytes[1] = {MOD_REG, 3'd0, req_i.reg_a};
        bytes[2] = req_i.imm[7:0];
        if (imm_small) begin
          bytes[0] = OP_ADD_IB;
          len      = 3'd3;
        end else begin
          bytes[0] = OP_ADD_ID;
          bytes[3] = req_i.imm[15:8];
          bytes[4] = req_i.imm[23:16];
          bytes[5] = req_i.imm[31:24];
          len      = 3'd6;
        end
      end
      CMD_RET: begin
        if (req_i.imm[15:0] == 16'd0) begin
          bytes[0] = OP_RET;
          len      = 3'd1;
        end else begin
          bytes[0] = OP_RET_IW;
          bytes[1] = req_i.imm[7:0];
          bytes[2] = req_i.imm[15:8];
          len      = 3'd3;
        end
      end
      CMD_TEST: begin
        bytes[0] = OP_TEST_RR;
        bytes[1] = {MOD_REG, req_i.reg_a, req_i.reg_a};
        len      = 3'd2;
      end
      CMD_INT3: begin
        bytes[0] = OP_INT3;
        len      = 3'd1;
      end
      default: begin
        // unused kinds produce nothing
        len = 3'd0;
      end
    endcase
  end

  assign req_i.ready = !qstat_i.full;
  assign accept      = req_i.valid && req_i.ready;
  assign push_o      = accept && (len != 3'd0);

  assign entry_o.bytes = bytes;
  assign entry_o.len   = len;
  assign entry_o.start = offset_q;
  assign entry_o.patch = (req_i.cmd == CMD_CALL_REL) ? (offset_q + 32'd1) : 32'd0;

  assign offset_d = push_o ? (offset_q + {29'd0, len}) : offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= 32'd0;
    end else begin
      offset_q <= offset_d;
    end
  end

endmodule

>>> hdl/xie_queue.sv
// ----------------------------------------------------------------------------
// xie_queue
// Small queue of encoded instructions between the encoder and the serializer.
// ----------------------------------------------------------------------------
module xie_queue import xie_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  xie_entry_t entry_i,
  input  logic       pop_i,
  output xie_entry_t head_o,
  output xie_qstat_t qstat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  xie_entry_t        mem_q [Depth];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign qstat_o.full  = (cnt_q == CntW'(Depth));
  assign qstat_o.empty = (cnt_q == '0);
  assign do_push       = push_i && !qstat_o.full;
  assign do_pop        = pop_i && !qstat_o.empty;
  assign head_o        = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

>>> hdl/xie_back.sv
// ----------------------------------------------------------------------------
// xie_back
// Serializes the head instruction into one code byte per cycle while the code channel is ready.
// ----------------------------------------------------------------------------
module xie_back import xie_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  xie_entry_t head_i,
  input  xie_qstat_t qstat_i,
  output logic       pop_o,
  xie_code_if.source code_o
);

  logic [2:0]  idx_q, idx_d;
  logic        valid_q, valid_d;
  logic [7:0]  byte_q;
  logic        last_q;
  logic [31:0] start_q, patch_q;
  logic        advance, emit, is_last;

  assign advance = !valid_q || code_o.ready;
  assign emit    = advance && !qstat_i.empty;
  assign is_last = ((idx_q + 3'd1) == head_i.len);
  assign pop_o   = emit && is_last;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (advance) begin
      valid_d = !qstat_i.empty;
    end
    if (emit) begin
      idx_d = is_last ? 3'd0 : idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 3'd0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      byte_q  <= head_i.bytes[idx_q];
      last_q  <= is_last;
      start_q <= head_i.start;
      patch_q <= head_i.patch;
    end
  end

  assign code_o.valid        = valid_q;
  assign code_o.code_byte    = byte_q;
  assign code_o.last_byte    = last_q;
  assign code_o.start_offset = start_q;
  assign code_o.patch_offset = patch_q;

endmodule
